// File: design/wrip_pkg.sv
package wrip_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] buffer_length;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [15:0] event_value;
    logic        proprietary;
    logic        is_rsn;
    logic        last_of_run;
  } out_item_t;

  // One decoded event, before the end-of-run marker is attached.
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic        prop;
    logic        rsn;
  } event_t;

  localparam int unsigned MAX_EVENTS = 7;

  // All events caused by one input byte; count is 1..MAX_EVENTS.
  typedef struct packed {
    logic [2:0]                  count;
    event_t [MAX_EVENTS-1:0]     ev;
  } run_t;

  typedef enum logic [11:0] {
    PH_ID     = 12'b0000_0000_0001,
    PH_LEN    = 12'b0000_0000_0010,
    PH_RAW    = 12'b0000_0000_0100,
    PH_HOLD   = 12'b0000_0000_1000,
    PH_VER    = 12'b0000_0001_0000,
    PH_GROUP  = 12'b0000_0010_0000,
    PH_PCNT   = 12'b0000_0100_0000,
    PH_PSUITE = 12'b0000_1000_0000,
    PH_ACNT   = 12'b0001_0000_0000,
    PH_ASUITE = 12'b0010_0000_0000,
    PH_CAP    = 12'b0100_0000_0000,
    PH_SKIP   = 12'b1000_0000_0000
  } phase_t;

  localparam logic [3:0] EV_START      = 4'd0;
  localparam logic [3:0] EV_RAW        = 4'd1;
  localparam logic [3:0] EV_VERSION    = 4'd2;
  localparam logic [3:0] EV_GROUP      = 4'd3;
  localparam logic [3:0] EV_GROUP_TKIP = 4'd4;
  localparam logic [3:0] EV_PAIR_TKIP  = 4'd5;
  localparam logic [3:0] EV_PCOUNT     = 4'd6;
  localparam logic [3:0] EV_PSUITE     = 4'd7;
  localparam logic [3:0] EV_ACOUNT     = 4'd8;
  localparam logic [3:0] EV_ASUITE     = 4'd9;
  localparam logic [3:0] EV_PREAUTH    = 4'd10;

  localparam logic [7:0] ID_RSN    = 8'h30;
  localparam logic [7:0] ID_VENDOR = 8'hdd;
  localparam logic [7:0] WPA_TYPE  = 8'h01;

  function automatic logic [7:0] oui_byte(input logic rsn, input logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (idx)
      2'd0: r = 8'h00;
      2'd1: r = rsn ? 8'h0f : 8'h50;
      2'd2: r = rsn ? 8'hac : 8'hf2;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic event_t mk_ev(input logic [3:0] kind, input logic [15:0] value,
                                   input logic prop, input logic rsn);
    event_t e;
    e.kind  = kind;
    e.value = value;
    e.prop  = prop;
    e.rsn   = (kind >= EV_VERSION) ? rsn : 1'b0;
    return e;
  endfunction

endpackage

// File: design/wrip_front.sv
module wrip_front
  import wrip_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_item_t item,
  output logic     run_push,
  output run_t     run
);

  phase_t      phase_r, cur_phase, nxt_phase;
  logic [15:0] rem_r, cur_rem, nxt_rem;
  logic [8:0]  pos_r, cur_pos, nxt_pos;
  logic [8:0]  eff_r, cur_eff, nxt_eff;
  logic        rsn_r, cur_rsn, nxt_rsn;
  logic [15:0] sl_r, cur_sl, nxt_sl;
  logic        om_r, cur_om, nxt_om;
  logic [7:0]  low_r, cur_low, nxt_low;
  logic [7:0]  held_r [6];
  logic        held_we;
  logic [2:0]  held_idx;

  logic [7:0]  b;
  logic [8:0]  p, left;
  logic [2:0]  n;
  logic        step;
  logic [16:0] want, avail;
  logic [15:0] cnt;
  logic [1:0]  sub;
  logic [7:0]  oui_b;
  logic        wpa_ok;

  assign b = item.data_byte;

  always_comb begin
    cur_phase = phase_r;
    cur_rem   = rem_r;
    cur_pos   = pos_r;
    cur_eff   = eff_r;
    cur_rsn   = rsn_r;
    cur_sl    = sl_r;
    cur_om    = om_r;
    cur_low   = low_r;
    if (item.first_byte) begin
      cur_phase = PH_ID;
      cur_rem   = item.buffer_length;
      cur_pos   = '0;
      cur_eff   = '0;
      cur_rsn   = 1'b0;
      cur_sl    = '0;
      cur_om    = 1'b1;
      cur_low   = '0;
    end

    nxt_phase = cur_phase;
    nxt_rem   = cur_rem;
    nxt_pos   = cur_pos;
    nxt_eff   = cur_eff;
    nxt_rsn   = cur_rsn;
    nxt_sl    = cur_sl;
    nxt_om    = cur_om;
    nxt_low   = cur_low;
    held_we   = 1'b0;
    held_idx  = '0;
    run       = '0;
    n         = '0;
    step      = 1'b0;
    p         = cur_pos;
    left      = (cur_eff > cur_pos) ? cur_eff - cur_pos - 9'd1 : '0;
    want      = {9'd0, b} + 17'd2;
    avail     = {1'b0, cur_rem} + 17'd1;
    cnt       = {b, cur_low};
    // pairwise suites start two bytes off the 4-byte grid of the other suites
    sub       = (cur_phase == PH_PSUITE) ? cur_pos[1:0] - 2'd2 : cur_pos[1:0];
    oui_b     = oui_byte(cur_rsn, sub);
    wpa_ok    = (held_r[2] == oui_byte(1'b0, 2'd0)) && (held_r[3] == oui_byte(1'b0, 2'd1)) &&
                (held_r[4] == oui_byte(1'b0, 2'd2)) && (b == WPA_TYPE);

    if (cur_rem != 16'd0) begin
      step = 1'b1;
      unique case (cur_phase)
        PH_ID: begin
          if (cur_rem < 16'd2) begin
            // lone trailing byte: consume silently
            step    = 1'b0;
            nxt_rem = cur_rem - 16'd1;
          end else begin
            p        = '0;
            held_we  = 1'b1;
            held_idx = 3'd0;
            nxt_rsn  = (b == ID_RSN);
            run.ev[n] = mk_ev(EV_START, {8'd0, b}, 1'b0, 1'b0);
            n = n + 3'd1;
            if (b != ID_RSN && b != ID_VENDOR) begin
              run.ev[n] = mk_ev(EV_RAW, {8'd0, b}, 1'b0, 1'b0);
              n = n + 3'd1;
            end
            nxt_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          held_we  = 1'b1;
          held_idx = 3'd1;
          nxt_eff  = (want < avail) ? want[8:0] : avail[8:0];
          if (held_r[0] == ID_RSN && nxt_eff >= 9'd4) begin
            nxt_phase = PH_VER;
          end else if (held_r[0] == ID_VENDOR && nxt_eff >= 9'd8) begin
            nxt_phase = PH_HOLD;
          end else begin
            if (held_r[0] == ID_RSN || held_r[0] == ID_VENDOR) begin
              run.ev[n] = mk_ev(EV_RAW, {8'd0, held_r[0]}, 1'b0, 1'b0);
              n = n + 3'd1;
            end
            run.ev[n] = mk_ev(EV_RAW, {8'd0, b}, 1'b0, 1'b0);
            n = n + 3'd1;
            nxt_phase = PH_RAW;
          end
        end
        PH_HOLD: begin
          if (p < 9'd6) begin
            held_we  = 1'b1;
            held_idx = p[2:0];
          end
          if (p >= 9'd5) begin
            if (wpa_ok) begin
              nxt_phase = PH_VER;
            end else begin
              for (int i = 0; i < 5; i++) begin
                run.ev[i] = mk_ev(EV_RAW, {8'd0, held_r[i]}, 1'b0, 1'b0);
              end
              run.ev[5] = mk_ev(EV_RAW, {8'd0, b}, 1'b0, 1'b0);
              n = 3'd6;
              nxt_phase = PH_RAW;
            end
          end
        end
        PH_VER: begin
          if (!p[0]) begin
            nxt_low = b;
          end else begin
            run.ev[n] = mk_ev(EV_VERSION, cnt, 1'b0, cur_rsn);
            n = n + 3'd1;
            if (left < 9'd4) begin
              run.ev[n] = mk_ev(EV_GROUP_TKIP, 16'd0, 1'b0, cur_rsn);
              n = n + 3'd1;
              run.ev[n] = mk_ev(EV_PAIR_TKIP, 16'd0, 1'b0, cur_rsn);
              n = n + 3'd1;
              nxt_phase = PH_SKIP;
            end else begin
              nxt_phase = PH_GROUP;
            end
          end
        end
        PH_GROUP, PH_PSUITE, PH_ASUITE: begin
          if (sub != 2'd3) begin
            // track the suite OUI
            if (sub == 2'd0) nxt_om = (b == oui_b);
            else             nxt_om = cur_om & (b == oui_b);
          end else if (cur_phase == PH_GROUP) begin
            run.ev[n] = mk_ev(EV_GROUP, {8'd0, b}, !cur_om, cur_rsn);
            n = n + 3'd1;
            if (left < 9'd2) begin
              run.ev[n] = mk_ev(EV_PAIR_TKIP, 16'd0, 1'b0, cur_rsn);
              n = n + 3'd1;
              nxt_phase = PH_SKIP;
            end else begin
              nxt_phase = PH_PCNT;
            end
          end else begin
            run.ev[n] = mk_ev((cur_phase == PH_PSUITE) ? EV_PSUITE : EV_ASUITE,
                              {8'd0, b}, !cur_om, cur_rsn);
            n = n + 3'd1;
            if (cur_sl != 16'd0) nxt_sl = cur_sl - 16'd1;
            if (nxt_sl == 16'd0) begin
              if (cur_phase == PH_PSUITE) nxt_phase = (left < 9'd2) ? PH_SKIP : PH_ACNT;
              else                        nxt_phase = (left < 9'd1) ? PH_SKIP : PH_CAP;
            end
          end
        end
        PH_PCNT, PH_ACNT: begin
          if (!p[0]) begin
            nxt_low = b;
          end else begin
            run.ev[n] = mk_ev((cur_phase == PH_PCNT) ? EV_PCOUNT : EV_ACOUNT,
                              cnt, 1'b0, cur_rsn);
            n = n + 3'd1;
            if ({9'd0, left} < {cnt, 2'b00}) begin
              nxt_phase = PH_SKIP;
            end else if (cnt != 16'd0) begin
              nxt_sl    = cnt;
              nxt_phase = (cur_phase == PH_PCNT) ? PH_PSUITE : PH_ASUITE;
            end else if (cur_phase == PH_PCNT) begin
              nxt_phase = (left < 9'd2) ? PH_SKIP : PH_ACNT;
            end else begin
              nxt_phase = (left < 9'd1) ? PH_SKIP : PH_CAP;
            end
          end
        end
        PH_CAP: begin
          if (b[0]) begin
            run.ev[n] = mk_ev(EV_PREAUTH, 16'd0, 1'b0, cur_rsn);
            n = n + 3'd1;
          end
          nxt_phase = PH_SKIP;
        end
        PH_RAW: begin
          run.ev[n] = mk_ev(EV_RAW, {8'd0, b}, 1'b0, 1'b0);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
    end

    if (step) begin
      nxt_pos = p + 9'd1;
      nxt_rem = cur_rem - 16'd1;
      if (nxt_pos >= 9'd2 && nxt_pos >= nxt_eff) nxt_phase = PH_ID;
    end
    run.count = n;
  end

  assign run_push = acc && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID;
      rem_r   <= '0;
      pos_r   <= '0;
      eff_r   <= '0;
      rsn_r   <= 1'b0;
      sl_r    <= '0;
      om_r    <= 1'b1;
      low_r   <= '0;
    end else if (acc) begin
      phase_r <= nxt_phase;
      rem_r   <= nxt_rem;
      pos_r   <= nxt_pos;
      eff_r   <= nxt_eff;
      rsn_r   <= nxt_rsn;
      sl_r    <= nxt_sl;
      om_r    <= nxt_om;
      low_r   <= nxt_low;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && held_we) held_r[held_idx] <= b;
  end

endmodule

// File: design/wrip_queue.sv
module wrip_queue
  import wrip_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t push_data,
  input  logic pop,
  output run_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == CW'(0));
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = mem[rd_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= bump(wr_r);
      if (pop)  rd_r <= bump(rd_r);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
  end

endmodule

// File: design/wrip_back.sv
module wrip_back
  import wrip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  run_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  logic [2:0] idx_r;
  logic       last;
  event_t     ev;

  assign ev        = head.ev[idx_r];
  assign last      = (idx_r == head.count - 3'd1);
  assign out_empty = q_empty;
  assign q_pop     = out_pop && !q_empty && last;

  always_comb begin
    out_data.event_kind  = ev.kind;
    out_data.event_value = ev.value;
    out_data.proprietary = ev.prop;
    out_data.is_rsn      = ev.rsn;
    out_data.last_of_run = last;
  end

  // advance through the run, drop the entry after its last event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (out_pop && !q_empty) begin
      idx_r <= last ? 3'd0 : idx_r + 3'd1;
    end
  end

endmodule

// File: design/wpa_rsn_ie_parser.sv
// A byte's events are written into the run queue and reach the output ports once the
// runs ahead of them are sent. Throughput, while out_pop is held high: one byte per
// cycle while each byte yields at most one event, and one event per cycle on the output.
// The run queue between parser and event sender sets how far the input runs ahead.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to element id.
module wpa_rsn_ie_parser
  import wrip_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic acc, run_push, q_pop, q_empty;
  run_t run, head;

  assign acc = in_push && !in_full;

  wrip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .item     (in_data),
    .run_push (run_push),
    .run      (run)
  );

  wrip_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (run_push),
    .push_data (run),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (in_full)
  );

  wrip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
